[rtl/klms_pkg.sv]
// ----------------------------------------------------------------------------
// klms_pkg
// shared types and constants of the key and LED matrix scanner
// ----------------------------------------------------------------------------
package klms_pkg;

  // key press counter width and saturation value
  localparam int unsigned KEY_CNT_W = 8;
  localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX = {KEY_CNT_W{1'b1}};

  // key limit register width and compare width
  localparam int unsigned KEY_LIMIT_W = 8;
  localparam int unsigned KEY_CMP_W = (KEY_CNT_W > KEY_LIMIT_W) ? KEY_CNT_W : KEY_LIMIT_W;

  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned MOUNT_W  = 12;
  localparam logic [HANDLE_W-1:0] HANDLE_MAX = {HANDLE_W{1'b1}};
  localparam logic [MOUNT_W-1:0]  MOUNT_MAX  = {MOUNT_W{1'b1}};

  localparam int unsigned NUM_KEYS = 8;
  localparam int unsigned NUM_LINES = 4;
  localparam int unsigned NUM_ROWS = 4;

  // register reset values
  localparam logic [KEY_LIMIT_W-1:0] KEY_LIMIT_RST    = 8'd20;
  localparam logic [HANDLE_W-1:0]    HANDLE_LIMIT_RST = 16'd50;
  localparam logic [MOUNT_W-1:0]     MOUNT_THR_RST    = 12'd1500;

  // register map
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic [1:0] REG_KEY_LIMIT    = 2'd0;
  localparam logic [1:0] REG_HANDLE_LIMIT = 2'd1;
  localparam logic [1:0] REG_MOUNT_THR    = 2'd2;

  typedef enum logic [1:0] {
    MOUNT_UNMOUNTED = 2'd0,
    MOUNT_MOUNTING  = 2'd1,
    MOUNT_MOUNTED   = 2'd2
  } mount_state_e;

  typedef struct packed {
    logic [KEY_LIMIT_W-1:0] key_press_limit;
    logic [HANDLE_W-1:0]    handle_press_limit;
    logic [MOUNT_W-1:0]     mount_threshold;
  } cfg_t;

  typedef struct packed {
    logic [NUM_LINES-1:0] return_lines;
    logic                 handle_pin;
    logic                 mount_pin;
    logic [NUM_KEYS-1:0]  led_pattern;
  } in_item_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0]  key_pressed;
    logic [NUM_ROWS-1:0]  row_drive;
    logic                 return_is_output;
    logic [NUM_LINES-1:0] return_drive_level;
    logic                 handle_pressed;
    mount_state_e         mount_status;
  } res_item_t;

endpackage

[rtl/klms_if.sv]
// ----------------------------------------------------------------------------
// klms_if
// request channels of the scanner: tick requests in, result requests out
// ----------------------------------------------------------------------------
interface klms_in_if
  import klms_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [NUM_LINES-1:0] return_lines;
  logic                 handle_pin;
  logic                 mount_pin;
  logic [NUM_KEYS-1:0]  led_pattern;

  modport source (output valid, output return_lines, output handle_pin,
                  output mount_pin, output led_pattern, input ready);
  modport sink   (input valid, input return_lines, input handle_pin,
                  input mount_pin, input led_pattern, output ready);
endinterface

interface klms_out_if
  import klms_pkg::*;
  ;
  logic                 valid;
  logic                 ready;
  logic [NUM_KEYS-1:0]  key_pressed;
  logic [NUM_ROWS-1:0]  row_drive;
  logic                 return_is_output;
  logic [NUM_LINES-1:0] return_drive_level;
  logic                 handle_pressed;
  logic [1:0]           mount_status;

  modport source (output valid, output key_pressed, output row_drive,
                  output return_is_output, output return_drive_level,
                  output handle_pressed, output mount_status, input ready);
  modport sink   (input valid, input key_pressed, input row_drive,
                  input return_is_output, input return_drive_level,
                  input handle_pressed, input mount_status, output ready);
endinterface

[rtl/klms_apb_regs.sv]
// ----------------------------------------------------------------------------
// klms_apb_regs
// configuration registers behind an apb-style port
// ----------------------------------------------------------------------------
module klms_apb_regs
  import klms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_KEY_LIMIT:    cfg_d.key_press_limit    = pwdata[KEY_LIMIT_W-1:0];
        REG_HANDLE_LIMIT: cfg_d.handle_press_limit = pwdata[HANDLE_W-1:0];
        REG_MOUNT_THR:    cfg_d.mount_threshold    = pwdata[MOUNT_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_KEY_LIMIT:    prdata = APB_DATA_W'(cfg_q.key_press_limit);
      REG_HANDLE_LIMIT: prdata = APB_DATA_W'(cfg_q.handle_press_limit);
      REG_MOUNT_THR:    prdata = APB_DATA_W'(cfg_q.mount_threshold);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.key_press_limit    <= KEY_LIMIT_RST;
      cfg_q.handle_press_limit <= HANDLE_LIMIT_RST;
      cfg_q.mount_threshold    <= MOUNT_THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/klms_scan_core.sv]
// ----------------------------------------------------------------------------
// klms_scan_core
// scan phase, key debounce, handle and mount qualification for one tick
// ----------------------------------------------------------------------------
module klms_scan_core
  import klms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output res_item_t res_o
);

  logic [1:0]           phase_q, phase_d;
  logic [KEY_CNT_W-1:0] key_cnt_q [NUM_KEYS];
  logic [KEY_CNT_W-1:0] key_cnt_d [NUM_KEYS];
  logic [NUM_KEYS-1:0]  key_bits_q, key_bits_d;
  logic [HANDLE_W-1:0]  handle_cnt_q, handle_cnt_d;
  logic                 handle_flag;
  logic [MOUNT_W-1:0]   mount_cnt_q, mount_cnt_d;
  mount_state_e         mount_state_q, mount_state_d;
  logic [MOUNT_W:0]     mount_sum;

  // keys
  always_comb begin
    key_bits_d = key_bits_q;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_cnt_d[k] = key_cnt_q[k];
      // odd phases read keys, phase 3 serves the upper group
      if (phase_q[0] && (phase_q[1] == k[2])) begin
        if (item_i.return_lines[3 - k[1:0]]) begin
          if (key_cnt_q[k] != KEY_CNT_MAX) begin
            key_cnt_d[k] = key_cnt_q[k] + KEY_CNT_W'(1);
          end
          if (KEY_CMP_W'(key_cnt_d[k]) > KEY_CMP_W'(cfg_i.key_press_limit)) begin
            key_bits_d[k] = 1'b1;
          end
        end else begin
          key_cnt_d[k]  = '0;
          key_bits_d[k] = 1'b0;
        end
      end
    end
  end

  assign phase_d = phase_q + 2'd1;

  // handle: the flag follows the count on every tick, so it needs no register
  always_comb begin
    handle_cnt_d = handle_cnt_q;
    handle_flag  = 1'b0;
    if (!item_i.handle_pin) begin
      if (handle_cnt_q > cfg_i.handle_press_limit) begin
        handle_flag = 1'b1;
      end else if (handle_cnt_q != HANDLE_MAX) begin
        handle_cnt_d = handle_cnt_q + HANDLE_W'(1);
      end
    end else begin
      handle_cnt_d = '0;
    end
  end

  // mount: up by two while present, down by one while absent
  assign mount_sum = {1'b0, mount_cnt_q} + (MOUNT_W+1)'(2);

  always_comb begin
    mount_cnt_d   = mount_cnt_q;
    mount_state_d = mount_state_q;
    if (!item_i.mount_pin) begin
      if (mount_cnt_q > cfg_i.mount_threshold) begin
        mount_state_d = MOUNT_MOUNTED;
      end else begin
        mount_state_d = MOUNT_MOUNTING;
        mount_cnt_d   = mount_sum[MOUNT_W] ? MOUNT_MAX : mount_sum[MOUNT_W-1:0];
      end
    end else if (mount_cnt_q != '0) begin
      mount_cnt_d = mount_cnt_q - MOUNT_W'(1);
    end else begin
      mount_state_d = MOUNT_UNMOUNTED;
    end
  end

  // result of this tick
  always_comb begin
    res_o.key_pressed      = key_bits_d;
    res_o.row_drive        = NUM_ROWS'(1) << phase_d;
    res_o.return_is_output = ~phase_d[0];
    case (phase_d)
      2'd0:    res_o.return_drive_level = ~item_i.led_pattern[7:4];
      2'd2:    res_o.return_drive_level = ~item_i.led_pattern[3:0];
      default: res_o.return_drive_level = '0;
    endcase
    res_o.handle_pressed = handle_flag;
    res_o.mount_status   = mount_state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= '0;
      key_bits_q    <= '0;
      handle_cnt_q  <= '0;
      mount_cnt_q   <= '0;
      mount_state_q <= MOUNT_UNMOUNTED;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_cnt_q[k] <= '0;
      end
    end else if (step_i) begin
      phase_q       <= phase_d;
      key_bits_q    <= key_bits_d;
      handle_cnt_q  <= handle_cnt_d;
      mount_cnt_q   <= mount_cnt_d;
      mount_state_q <= mount_state_d;
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_cnt_q[k] <= key_cnt_d[k];
      end
    end
  end

endmodule

[rtl/key_led_matrix_scanner_core.sv]
// ----------------------------------------------------------------------------
// key_led_matrix_scanner_core
// scanner for a 2x4 key matrix and a 2x4 led matrix with debounce
//
// Each request on the input channel is one 1 ms scan tick carrying the
// sampled return lines, the handle and mount pin levels and the led pattern;
// every tick gives exactly one result request with the debounced key bits,
// the one-hot row drive of the new phase, the return line direction and
// levels, the qualified handle state and the mount status. One tick is taken
// in every cycle while the result side does not stall; the input register
// takes an accepted tick, and the state update carries it from there into
// the result register, from which its result is offered. A stalled
// result holds the tick in the input register and drops the input ready. The
// key, handle and mount counters and the scan phase are updated in a single
// pass as a tick moves from the input register to the result register, so a
// new tick can enter the input register while the last one passes on. The
// user must write configuration through the apb-style port while no tick
// is in flight, unenforced by the block; no clearing pass follows reset.
// ----------------------------------------------------------------------------
module key_led_matrix_scanner_core
  import klms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  klms_in_if.sink               in_ch,
  klms_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q;
  res_item_t res_d, res_q;
  logic      res_valid_q;
  logic      advance;
  logic      in_take;

  // configuration registers
  klms_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // a tick moves on when the result register is empty or being emptied
  assign advance = in_valid_q & (~res_valid_q | out_ch.ready);
  // the input register refills in the same cycle it drains
  assign in_ch.ready = ~in_valid_q | advance;
  assign in_take     = in_ch.valid & in_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.return_lines <= in_ch.return_lines;
      in_item_q.handle_pin   <= in_ch.handle_pin;
      in_item_q.mount_pin    <= in_ch.mount_pin;
      in_item_q.led_pattern  <= in_ch.led_pattern;
    end
  end

  // scan state and per-tick logic
  klms_scan_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_ch.valid              = res_valid_q;
  assign out_ch.key_pressed        = res_q.key_pressed;
  assign out_ch.row_drive          = res_q.row_drive;
  assign out_ch.return_is_output   = res_q.return_is_output;
  assign out_ch.return_drive_level = res_q.return_drive_level;
  assign out_ch.handle_pressed     = res_q.handle_pressed;
  assign out_ch.mount_status       = res_q.mount_status;

`ifndef SYNTHESIS
  // a held tick is never dropped while the result side stalls
  a_tick_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("tick lost in input register");

  // exactly one row line is driven
  a_row_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> $onehot(out_ch.row_drive))
    else $error("row drive not one-hot");

  // return lines are outputs only in the led rows
  a_dir_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.return_is_output ==
                      (out_ch.row_drive[0] | out_ch.row_drive[2])))
    else $error("return direction does not match row");

  // input rows leave the output latch cleared
  a_input_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && !out_ch.return_is_output) |-> (out_ch.return_drive_level == '0))
    else $error("drive level set while return lines are inputs");
`endif

endmodule
